### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies; used by every other file of the block.
package rau_pkg;

  localparam int unsigned OperandBitsDefault = 16;
  localparam int unsigned NumBits = 32;
  localparam int unsigned DenBits = 31;
  localparam int unsigned OrdBits = 2;
  localparam int unsigned CmdBits = 3;
  localparam int unsigned MagBits = 66;

  localparam logic [CmdBits-1:0] CmdAdd = 3'd0;
  localparam logic [CmdBits-1:0] CmdSub = 3'd1;
  localparam logic [CmdBits-1:0] CmdMul = 3'd2;
  localparam logic [CmdBits-1:0] CmdDiv = 3'd3;
  localparam logic [CmdBits-1:0] CmdCmp = 3'd4;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic combine;
    logic gcd_start;
    logic div_num;
    logic div_den;
    logic finish;
  } rau_cmd_t;

  typedef struct packed {
    logic reduce;
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

### rtl/rau_datapath.sv
// Datapath of the rational arithmetic unit: products, subtractive-free GCD by
// shift-subtract remainder, and two restoring divisions. Depends on rau_pkg.
module rau_datapath #(
  parameter int unsigned OperandBits = rau_pkg::OperandBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rau_pkg::rau_cmd_t             cmd_i,
  output rau_pkg::rau_stat_t            stat_o,
  input  logic [rau_pkg::CmdBits-1:0]   command_i,
  input  logic [OperandBits-1:0]        a_num_i,
  input  logic [OperandBits-1:0]        a_den_i,
  input  logic [OperandBits-1:0]        b_num_i,
  input  logic [OperandBits-1:0]        b_den_i,
  output logic [rau_pkg::NumBits-1:0]   result_num_o,
  output logic [rau_pkg::DenBits-1:0]   result_den_o,
  output logic [rau_pkg::OrdBits-1:0]   ordering_o,
  output logic                          undefined_o
);

  localparam int unsigned PB = 2 * OperandBits + 2;
  localparam int unsigned MB = rau_pkg::MagBits;
  localparam int unsigned CB = $clog2(MB + 1);

  logic [rau_pkg::CmdBits-1:0] cmd_q;
  logic signed [OperandBits-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PB-1:0] p0_q, p1_q, p2_q;
  logic signed [PB-1:0] n_q, d_q;
  logic [MB-1:0] x_q, y_q, g_q, quo_q, rem_q, dvd_q;
  logic [CB-1:0] cnt_q;
  logic gcd_busy_q, div_busy_q, gcd_done_q, div_done_q, in_mod_q;
  logic neg_q;
  logic [MB-1:0] qn_q;
  logic signed [2*OperandBits-1:0] m0, m1, m2;

  function automatic logic signed [OperandBits-1:0] sat(input logic [OperandBits-1:0] v);
    logic [OperandBits-1:0] mn;
    mn = {1'b1, {(OperandBits-1){1'b0}}};
    sat = (v == mn) ? OperandBits'(mn + 1'b1) : v;
  endfunction

  logic [MB:0] trial;
  logic [MB-1:0] sh_rem;
  assign sh_rem = {rem_q[MB-2:0], dvd_q[MB-1]};
  assign trial = {1'b0, sh_rem} - {1'b0, (in_mod_q ? y_q : g_q)};

  assign m0 = an_q * ((cmd_q == rau_pkg::CmdMul) ? bn_q : bd_q);
  assign m1 = bn_q * ad_q;
  assign m2 = ad_q * ((cmd_q == rau_pkg::CmdDiv) ? bn_q : bd_q);

  assign stat_o.reduce = (n_q != '0) && (d_q != '0) && (cmd_q <= rau_pkg::CmdDiv);
  assign stat_o.gcd_done = gcd_done_q;
  assign stat_o.div_done = div_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcd_busy_q <= 1'b0;
      div_busy_q <= 1'b0;
      gcd_done_q <= 1'b0;
      div_done_q <= 1'b0;
      in_mod_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      gcd_done_q <= 1'b0;
      div_done_q <= 1'b0;
      if (cmd_i.gcd_start) begin
        x_q <= MB'(n_q < 0 ? -n_q : n_q);
        y_q <= MB'(d_q < 0 ? -d_q : d_q);
        neg_q <= (n_q < 0) != (d_q < 0);
        gcd_busy_q <= 1'b1;
        in_mod_q <= 1'b0;
      end else if (gcd_busy_q && !in_mod_q) begin
        if (y_q == '0) begin
          g_q <= x_q;
          gcd_busy_q <= 1'b0;
          gcd_done_q <= 1'b1;
        end else begin
          dvd_q <= x_q;
          rem_q <= '0;
          cnt_q <= CB'(MB);
          in_mod_q <= 1'b1;
        end
      end else if (gcd_busy_q && in_mod_q) begin
        dvd_q <= {dvd_q[MB-2:0], 1'b0};
        rem_q <= trial[MB] ? sh_rem : trial[MB-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          x_q <= y_q;
          y_q <= trial[MB] ? sh_rem : trial[MB-1:0];
          in_mod_q <= 1'b0;
        end
      end
      if (cmd_i.div_num || cmd_i.div_den) begin
        dvd_q <= cmd_i.div_num ? MB'(n_q < 0 ? -n_q : n_q) : MB'(d_q < 0 ? -d_q : d_q);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CB'(MB);
        div_busy_q <= 1'b1;
      end else if (div_busy_q) begin
        dvd_q <= {dvd_q[MB-2:0], 1'b0};
        rem_q <= trial[MB] ? sh_rem : trial[MB-1:0];
        quo_q <= {quo_q[MB-2:0], ~trial[MB]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
      if (div_done_q && !cmd_i.finish) qn_q <= quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      an_q <= sat(a_num_i);
      ad_q <= sat(a_den_i);
      bn_q <= sat(b_num_i);
      bd_q <= sat(b_den_i);
    end
    if (cmd_i.mul1) begin
      p0_q <= PB'(m0);
      p1_q <= PB'(m1);
    end
    if (cmd_i.mul2) begin
      p2_q <= PB'(m2);
    end
    if (cmd_i.combine) begin
      case (cmd_q)
        rau_pkg::CmdAdd: begin n_q <= p0_q + p1_q; d_q <= p2_q; end
        rau_pkg::CmdSub: begin n_q <= p0_q - p1_q; d_q <= p2_q; end
        default: begin n_q <= p0_q; d_q <= p2_q; end
      endcase
    end
    if (cmd_i.finish) begin
      result_num_o <= '0;
      result_den_o <= '0;
      ordering_o <= '0;
      undefined_o <= 1'b0;
      if (cmd_q == rau_pkg::CmdCmp) begin
        ordering_o <= (p0_q > p1_q) ? 2'sd1 : (p0_q < p1_q) ? -2'sd1 : 2'sd0;
      end else if (cmd_q <= rau_pkg::CmdDiv) begin
        undefined_o <= (d_q == '0);
        if (stat_o.reduce) begin
          result_num_o <= rau_pkg::NumBits'(neg_q ? -qn_q : qn_q);
          result_den_o <= rau_pkg::DenBits'(quo_q);
        end else begin
          result_num_o <= rau_pkg::NumBits'(n_q);
          result_den_o <= rau_pkg::DenBits'(d_q);
        end
      end
    end
  end

endmodule

### rtl/rau_ctrl.sv
// Sequencer of the rational arithmetic unit.
// Depends on rau_pkg; drives rau_datapath by command signals.
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output rau_pkg::rau_cmd_t  cmd_o,
  input  rau_pkg::rau_stat_t stat_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul1 = 4'd1;
  localparam logic [3:0] StMul2 = 4'd2;
  localparam logic [3:0] StComb = 4'd3;
  localparam logic [3:0] StChk  = 4'd4;
  localparam logic [3:0] StGcd  = 4'd5;
  localparam logic [3:0] StDivN = 4'd6;
  localparam logic [3:0] StDivD = 4'd7;
  localparam logic [3:0] StFin  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;
  localparam logic [3:0] StWGcd = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: if (start_i) begin cmd_o.load = 1'b1; state_d = StMul1; end
      StMul1: begin cmd_o.mul1 = 1'b1; state_d = StMul2; end
      StMul2: begin cmd_o.mul2 = 1'b1; state_d = StComb; end
      StComb: begin cmd_o.combine = 1'b1; state_d = StChk; end
      StChk: begin
        if (stat_i.reduce) begin cmd_o.gcd_start = 1'b1; state_d = StWGcd; end
        else state_d = StFin;
      end
      StWGcd: if (stat_i.gcd_done) begin cmd_o.div_num = 1'b1; state_d = StDivN; end
      StDivN: if (stat_i.div_done) begin cmd_o.div_den = 1'b1; state_d = StDivD; end
      StDivD: if (stat_i.div_done) begin cmd_o.finish = 1'b1; state_d = StOut; end
      StFin: begin cmd_o.finish = 1'b1; state_d = StOut; end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

endmodule

### rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares
// two fractions, reducing arithmetic results by their GCD when numerator and denominator are nonzero.
// Channels: a beat is taken when start_i is high and busy_o is low; the
// result beat is shown for one cycle with done_o high and cannot be held off.
// Compare and unreduced results go through the multiply, combine, check and
// finish states. Reduced results add the Euclidean loop, one remainder step
// at a time on a shared restoring shift-subtract unit, then two divisions on it.
// One item is in work at a time; busy_o stays high until done_o.
// Reset clears the sequencer; no result is pending afterwards.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
module rational_arithmetic_unit #(
  parameter int unsigned OperandBits = rau_pkg::OperandBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  output logic                        done_o,
  input  logic [rau_pkg::CmdBits-1:0] command_i,
  input  logic [OperandBits-1:0]      a_num_i,
  input  logic [OperandBits-1:0]      a_den_i,
  input  logic [OperandBits-1:0]      b_num_i,
  input  logic [OperandBits-1:0]      b_den_i,
  output logic [rau_pkg::NumBits-1:0] result_num_o,
  output logic [rau_pkg::DenBits-1:0] result_den_o,
  output logic [rau_pkg::OrdBits-1:0] ordering_o,
  output logic                        undefined_o
);

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .cmd_o(cmd), .stat_i(stat)
  );

  rau_datapath #(.OperandBits(OperandBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .command_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .result_num_o, .result_den_o, .ordering_o, .undefined_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");

endmodule

### tb/tb.sv
// Self-checking testbench for the rational arithmetic unit: drives fraction commands
// and compares every result beat against a predictor of the reduced fraction.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [rau_pkg::NumBits-1:0] num;
    logic [rau_pkg::DenBits-1:0] den;
    logic [rau_pkg::OrdBits-1:0] ord;
    logic                        undef;
  } fraction_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           busy_o;
  logic                           done_o;
  logic [rau_pkg::CmdBits-1:0]    command_i = '0;
  logic [15:0]                    a_num_i = '0;
  logic [15:0]                    a_den_i = '0;
  logic [15:0]                    b_num_i = '0;
  logic [15:0]                    b_den_i = '0;
  logic [rau_pkg::NumBits-1:0]    result_num_o;
  logic [rau_pkg::DenBits-1:0]    result_den_o;
  logic [rau_pkg::OrdBits-1:0]    ordering_o;
  logic                           undefined_o;

  fraction_t pending_fractions[$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  bit        gaps_on = 1'b1;

  localparam int QuietLimit = 40000;

  always #5 clk_i = ~clk_i;

  rational_arithmetic_unit DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .command_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .result_num_o, .result_den_o, .ordering_o, .undefined_o
  );

  function automatic longint operand_value(logic [15:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v < -32767) v = -32767;
    return v;
  endfunction

  function automatic fraction_t reduce_fraction(logic [rau_pkg::CmdBits-1:0] cmd,
                                                logic [15:0] an_r, logic [15:0] ad_r,
                                                logic [15:0] bn_r, logic [15:0] bd_r);
    fraction_t r;
    longint an, ad, bn, bd, n, d, lhs, rhs;
    longint unsigned un, ud, x, y, t;
    an = operand_value(an_r);
    ad = operand_value(ad_r);
    bn = operand_value(bn_r);
    bd = operand_value(bd_r);
    r = '0;
    case (cmd)
      rau_pkg::CmdAdd: begin n = an * bd + bn * ad; d = ad * bd; end
      rau_pkg::CmdSub: begin n = an * bd - bn * ad; d = ad * bd; end
      rau_pkg::CmdMul: begin n = an * bn; d = ad * bd; end
      rau_pkg::CmdDiv: begin n = an * bd; d = ad * bn; end
      rau_pkg::CmdCmp: begin
        lhs = an * bd;
        rhs = bn * ad;
        if (lhs > rhs) r.ord = 2'b01;
        else if (lhs < rhs) r.ord = 2'b11;
        return r;
      end
      default: return r;
    endcase
    if (n != 0 && d != 0) begin
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      x = un;
      y = ud;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      un = un / x;
      ud = ud / x;
      t = ((n < 0) != (d < 0)) ? -un : un;
      r.num = t[rau_pkg::NumBits-1:0];
      r.den = ud[rau_pkg::DenBits-1:0];
    end else begin
      r.num = n[rau_pkg::NumBits-1:0];
      r.den = d[rau_pkg::DenBits-1:0];
    end
    r.undef = (d == 0);
    return r;
  endfunction

  task automatic send_beat(logic [rau_pkg::CmdBits-1:0] cmd, logic [15:0] an,
                           logic [15:0] ad, logic [15:0] bn, logic [15:0] bd);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    a_num_i   <= an;
    a_den_i   <= ad;
    b_num_i   <= bn;
    b_den_i   <= bd;
    do @(posedge clk_i); while (busy_o);
    pending_fractions.push_back(reduce_fraction(cmd, an, ad, bn, bd));
  endtask

  task automatic wait_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_fractions.size() > 0);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3, 4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
      6: return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [rau_pkg::CmdBits-1:0] pick_command();
    if ($urandom_range(0, 19) == 0) return rau_pkg::CmdBits'($urandom_range(5, 7));
    return rau_pkg::CmdBits'($urandom_range(0, 4));
  endfunction

  task automatic test_directed();
    send_beat(rau_pkg::CmdAdd, 16'd1, 16'd2, 16'd1, 16'd3);
    send_beat(rau_pkg::CmdSub, 16'd1, 16'd2, 16'd1, 16'd2);
    send_beat(rau_pkg::CmdMul, 16'h7fff, 16'd1, 16'h7fff, 16'd1);
    send_beat(rau_pkg::CmdDiv, 16'h8000, 16'h7fff, 16'h8001, 16'd1);
    send_beat(rau_pkg::CmdCmp, 16'd1, 16'd3, 16'd1, 16'd2);
    send_beat(rau_pkg::CmdCmp, 16'd2, 16'd4, 16'd1, 16'd2);
    send_beat(rau_pkg::CmdCmp, 16'h7fff, 16'd1, 16'h8000, 16'd1);
    send_beat(rau_pkg::CmdAdd, 16'd5, 16'd0, 16'd3, 16'd7);
    send_beat(rau_pkg::CmdDiv, 16'd5, 16'd7, 16'd0, 16'd3);
    send_beat(rau_pkg::CmdMul, 16'd0, 16'hfffd, 16'd4, 16'd5);
    send_beat(rau_pkg::CmdSub, 16'hffff, 16'h8000, 16'h7fff, 16'h8001);
    send_beat(rau_pkg::CmdAdd, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(rau_pkg::CmdMul, 16'hfff6, 16'd4, 16'd6, 16'hfff1);
    send_beat(rau_pkg::CmdDiv, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(3'd5, 16'd1, 16'd1, 16'd1, 16'd1);
    send_beat(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_beat(3'd7, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_beat(rau_pkg::CmdCmp, 16'd3, 16'd0, 16'd2, 16'hffff);
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_beat(pick_command(), pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endtask

  task automatic test_drain_pause();
    wait_drain();
    test_random(50);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random(250);
  endtask

  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni && done_o) begin
      if (pending_fractions.size() == 0) begin
        $display("%t unexpected result num=%0d den=%0d", $realtime,
                 $signed(result_num_o), $signed(result_den_o));
        error_count++;
      end else begin
        want = pending_fractions.pop_front();
        if (result_num_o !== want.num) begin
          $display("%t result_num expected %0d actual %0d", $realtime,
                   $signed(want.num), $signed(result_num_o));
          error_count++;
        end
        if (result_den_o !== want.den) begin
          $display("%t result_den expected %0d actual %0d", $realtime,
                   $signed(want.den), $signed(result_den_o));
          error_count++;
        end
        if (ordering_o !== want.ord) begin
          $display("%t ordering expected %0d actual %0d", $realtime,
                   $signed(want.ord), $signed(ordering_o));
          error_count++;
        end
        if (undefined_o !== want.undef) begin
          $display("%t undefined expected %0b actual %0b", $realtime,
                   want.undef, undefined_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_drain_pause();
    test_random(600);
    test_back_to_back();
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
